@@ design/ffca_pkg.sv @@
package ffca_pkg;

    localparam int HEADER_BYTES      = 16;
    localparam int MAX_FREE_SEGMENTS = 64;
    localparam int MAX_ALLOCATIONS   = 64;
    localparam int OFFSET_BITS       = 24;

    localparam int FIDX_W  = $clog2(MAX_FREE_SEGMENTS);
    localparam int FCNT_W  = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int UIDX_W  = $clog2(MAX_ALLOCATIONS);
    localparam int UCNT_W  = $clog2(MAX_ALLOCATIONS + 1);
    localparam int ENTRY_W = 2 * OFFSET_BITS;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_SH_RD,
        S_SH_WR,
        S_F_CHK,
        S_U_RD,
        S_U_CHK,
        S_P_RD,
        S_P_CHK,
        S_MERGE,
        S_IN_RD,
        S_IN_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
    } seg_t;

endpackage

@@ design/ffca_ram.sv @@
module ffca_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/first_fit_coalescing_allocator_core.sv @@
// channel | handshake          | payload
// cfg     | cfg_we             | cfg_index, cfg_data
// in      | in_valid, in_stall | command, request_bytes, user_address
// out     | out_valid, out_stall | status, granted_address
// One transaction at a time. Every table read takes an issue state and a use state on the
// single read port of the free or used table memory.
// Allocate scans free segments in order and may shift later entries down by one.
// Free skips empty used slots, compares valid ones, scans free entries and may shift
// entries up or down by one.
// No clearing pass after reset; a heap_bytes write while idle resets the tables.
// A finished result waits in the output register while the next transaction is taken.
module first_fit_coalescing_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [23:0] request_bytes,
    input  logic [31:0] user_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] granted_address
);
    import ffca_pkg::*;

    localparam int OFF_W = OFFSET_BITS;

    state_t state_reg, state_next;
    logic [31:0] heap_base_reg;
    logic [FCNT_W-1:0] fcount_reg, fcount_next;
    logic [MAX_ALLOCATIONS-1:0] uvalid_reg, uvalid_next;

    logic cmd_reg;
    logic [OFF_W-1:0] req_reg;
    logic [31:0] addr_reg;
    logic [FCNT_W-1:0] i_reg, i_next;
    logic [UCNT_W-1:0] k_reg, k_next;
    logic [FCNT_W-1:0] p_reg, p_next;
    logic [32:0] off_reg, off_next;
    logic [OFF_W-1:0] ulen_reg, ulen_next;
    logic [UIDX_W-1:0] uslot_reg, uslot_next;
    seg_t prev_reg, prev_next, nxt_reg, nxt_next;
    logic have_prev_reg, have_prev_next, have_nxt_reg, have_nxt_next;
    status_t res_st_reg, res_st_next;
    logic [31:0] res_addr_reg, res_addr_next;

    logic out_valid_reg;
    logic [1:0] status_reg;
    logic [31:0] granted_reg;

    logic f_we;
    logic [FIDX_W-1:0] f_waddr, f_raddr;
    seg_t f_wdata, f_rdata;
    logic [ENTRY_W-1:0] f_rraw;
    logic u_we;
    logic [UIDX_W-1:0] u_waddr, u_raddr;
    seg_t u_wdata, u_rdata;
    logic [ENTRY_W-1:0] u_rraw;

    logic slot_ok;
    logic [UIDX_W-1:0] slot_idx;
    logic init_we;
    logic [32:0] floor_w;
    logic [OFF_W+1:0] lo_end;
    logic [33:0] hi_end;
    logic join_lo, join_hi;

    ffca_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_FREE_SEGMENTS)) u_free_ram (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rraw)
    );
    ffca_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ALLOCATIONS)) u_used_ram (
        .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
        .raddr(u_raddr), .rdata(u_rraw)
    );
    assign f_rdata = seg_t'(f_rraw);
    assign u_rdata = seg_t'(u_rraw);

    // lowest empty allocation slot
    always_comb
    begin
        slot_ok  = 1'b0;
        slot_idx = '0;
        for (int n = MAX_ALLOCATIONS - 1; n >= 0; n--)
        begin
            if (!uvalid_reg[n])
            begin
                slot_ok  = 1'b1;
                slot_idx = UIDX_W'(n);
            end
        end
    end

    assign init_we = cfg_we && (cfg_index == CFG_HEAP_BYTES);
    assign floor_w = {1'b0, heap_base_reg} + 33'(HEADER_BYTES);
    assign lo_end  = (OFF_W+2)'(prev_reg.start) + (OFF_W+2)'(prev_reg.len)
                   + (OFF_W+2)'(HEADER_BYTES);
    assign hi_end  = {1'b0, off_reg} + 34'(ulen_reg) + 34'(HEADER_BYTES);
    assign join_lo = have_prev_reg && ({7'd0, lo_end} == off_reg);
    assign join_hi = have_nxt_reg && (hi_end == 34'(nxt_reg.start));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            heap_base_reg <= '0;
            fcount_reg    <= FCNT_W'(1);
            uvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fcount_reg <= fcount_next;
            uvalid_reg <= uvalid_next;
            if (cfg_we && cfg_index == CFG_HEAP_BASE)
            begin
                heap_base_reg <= cfg_data;
            end
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg  <= command;
            req_reg  <= request_bytes;
            addr_reg <= user_address;
        end
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            status_reg  <= res_st_reg;
            granted_reg <= res_addr_reg;
        end
        i_reg         <= i_next;
        k_reg         <= k_next;
        p_reg         <= p_next;
        off_reg       <= off_next;
        ulen_reg      <= ulen_next;
        uslot_reg     <= uslot_next;
        prev_reg      <= prev_next;
        nxt_reg       <= nxt_next;
        have_prev_reg <= have_prev_next;
        have_nxt_reg  <= have_nxt_next;
        res_st_reg    <= res_st_next;
        res_addr_reg  <= res_addr_next;
    end

    // entry 0 of the free table is loaded while boot_reg is set after reset
    logic boot_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg <= 1'b1;
        end
        else
        begin
            boot_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fcount_next    = fcount_reg;
        uvalid_next    = uvalid_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        off_next       = off_reg;
        ulen_next      = ulen_reg;
        uslot_next     = uslot_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        have_prev_next = have_prev_reg;
        have_nxt_next  = have_nxt_reg;
        res_st_next    = res_st_reg;
        res_addr_next  = res_addr_reg;
        f_we    = 1'b0;
        f_waddr = '0;
        f_wdata = '0;
        f_raddr = '0;
        u_we    = 1'b0;
        u_waddr = uslot_reg;
        u_wdata = '0;
        u_raddr = k_reg[UIDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (init_we)
                begin
                    uvalid_next = '0;
                    if (cfg_data[OFF_W-1:0] > OFF_W'(HEADER_BYTES))
                    begin
                        f_we        = 1'b1;
                        f_wdata.len = cfg_data[OFF_W-1:0] - OFF_W'(HEADER_BYTES);
                        fcount_next = FCNT_W'(1);
                    end
                    else
                    begin
                        fcount_next = '0;
                    end
                end
                else if (boot_reg)
                begin
                    f_we        = 1'b1;
                    f_wdata.len = OFF_W'(1048576 - HEADER_BYTES);
                end
                else if (in_valid)
                begin
                    i_next        = '0;
                    k_next        = '0;
                    res_addr_next = '0;
                    state_next    = (command == CMD_FREE) ? S_F_CHK : S_A_RD;
                end
            end
            S_A_RD:
            begin
                f_raddr = i_reg[FIDX_W-1:0];
                if (i_reg < fcount_reg)
                begin
                    state_next = S_A_CHK;
                end
                else
                begin
                    res_st_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
            end
            S_A_CHK:
            begin
                if (f_rdata.len > req_reg)
                begin
                    if (!slot_ok)
                    begin
                        res_st_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        u_we          = 1'b1;
                        u_waddr       = slot_idx;
                        u_wdata.start = f_rdata.start;
                        uvalid_next[slot_idx] = 1'b1;
                        res_st_next   = ST_OK;
                        res_addr_next = heap_base_reg + 32'(f_rdata.start)
                                      + 32'(HEADER_BYTES);
                        if (f_rdata.len - req_reg <= OFF_W'(HEADER_BYTES))
                        begin
                            u_wdata.len = f_rdata.len;
                            p_next      = i_reg + FCNT_W'(1);
                            state_next  = S_SH_RD;
                        end
                        else
                        begin
                            u_wdata.len   = req_reg;
                            f_we          = 1'b1;
                            f_waddr       = i_reg[FIDX_W-1:0];
                            f_wdata.start = f_rdata.start + OFF_W'(HEADER_BYTES) + req_reg;
                            f_wdata.len   = f_rdata.len - req_reg - OFF_W'(HEADER_BYTES);
                            state_next    = S_DONE;
                        end
                    end
                end
                else
                begin
                    i_next     = i_reg + FCNT_W'(1);
                    state_next = S_A_RD;
                end
            end
            // remove entry p-1: move p..count-1 down by one
            S_SH_RD:
            begin
                f_raddr = p_reg[FIDX_W-1:0];
                if (p_reg < fcount_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    fcount_next = fcount_reg - FCNT_W'(1);
                    state_next  = S_DONE;
                end
            end
            S_SH_WR:
            begin
                f_we       = 1'b1;
                f_waddr    = FIDX_W'(p_reg - FCNT_W'(1));
                f_wdata    = f_rdata;
                p_next     = p_reg + FCNT_W'(1);
                state_next = S_SH_RD;
            end
            S_F_CHK:
            begin
                off_next = {1'b0, addr_reg} - floor_w;
                if ({1'b0, addr_reg} < floor_w)
                begin
                    res_st_next = ST_BAD_ADDR;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_U_RD;
                end
            end
            S_U_RD:
            begin
                if (k_reg == UCNT_W'(MAX_ALLOCATIONS))
                begin
                    res_st_next = ST_BAD_ADDR;
                    state_next  = S_DONE;
                end
                else if (!uvalid_reg[k_reg[UIDX_W-1:0]])
                begin
                    k_next = k_reg + UCNT_W'(1);
                end
                else
                begin
                    state_next = S_U_CHK;
                end
            end
            S_U_CHK:
            begin
                if (33'(u_rdata.start) == off_reg)
                begin
                    uslot_next     = k_reg[UIDX_W-1:0];
                    ulen_next      = u_rdata.len;
                    p_next         = '0;
                    have_prev_next = 1'b0;
                    have_nxt_next  = 1'b0;
                    state_next     = S_P_RD;
                end
                else
                begin
                    k_next     = k_reg + UCNT_W'(1);
                    state_next = S_U_RD;
                end
            end
            S_P_RD:
            begin
                f_raddr    = p_reg[FIDX_W-1:0];
                state_next = (p_reg < fcount_reg) ? S_P_CHK : S_MERGE;
            end
            S_P_CHK:
            begin
                if (33'(f_rdata.start) <= off_reg)
                begin
                    prev_next      = f_rdata;
                    have_prev_next = 1'b1;
                    p_next         = p_reg + FCNT_W'(1);
                    state_next     = S_P_RD;
                end
                else
                begin
                    nxt_next      = f_rdata;
                    have_nxt_next = 1'b1;
                    state_next    = S_MERGE;
                end
            end
            S_MERGE:
            begin
                res_st_next = ST_OK;
                state_next  = S_DONE;
                if (join_lo || join_hi)
                begin
                    uvalid_next[uslot_reg] = 1'b0;
                    f_we = 1'b1;
                end
                if (join_lo && join_hi)
                begin
                    f_waddr       = FIDX_W'(p_reg - FCNT_W'(1));
                    f_wdata.start = prev_reg.start;
                    f_wdata.len   = prev_reg.len + ulen_reg + nxt_reg.len
                                  + OFF_W'(2 * HEADER_BYTES);
                    p_next        = p_reg + FCNT_W'(1);
                    state_next    = S_SH_RD;
                end
                else if (join_lo)
                begin
                    f_waddr       = FIDX_W'(p_reg - FCNT_W'(1));
                    f_wdata.start = prev_reg.start;
                    f_wdata.len   = prev_reg.len + ulen_reg + OFF_W'(HEADER_BYTES);
                end
                else if (join_hi)
                begin
                    f_waddr       = p_reg[FIDX_W-1:0];
                    f_wdata.start = off_reg[OFF_W-1:0];
                    f_wdata.len   = nxt_reg.len + ulen_reg + OFF_W'(HEADER_BYTES);
                end
                else if (fcount_reg >= FCNT_W'(MAX_FREE_SEGMENTS))
                begin
                    res_st_next = ST_FULL;
                end
                else
                begin
                    uvalid_next[uslot_reg] = 1'b0;
                    i_next     = fcount_reg;
                    state_next = S_IN_RD;
                end
            end
            // open a hole at p: move p..count-1 up by one
            S_IN_RD:
            begin
                f_raddr = FIDX_W'(i_reg - FCNT_W'(1));
                if (i_reg > p_reg)
                begin
                    state_next = S_IN_WR;
                end
                else
                begin
                    f_we          = 1'b1;
                    f_waddr       = p_reg[FIDX_W-1:0];
                    f_wdata.start = off_reg[OFF_W-1:0];
                    f_wdata.len   = ulen_reg;
                    fcount_next   = fcount_reg + FCNT_W'(1);
                    state_next    = S_DONE;
                end
            end
            S_IN_WR:
            begin
                f_we       = 1'b1;
                f_waddr    = i_reg[FIDX_W-1:0];
                f_wdata    = f_rdata;
                i_next     = i_reg - FCNT_W'(1);
                state_next = S_IN_RD;
            end
            S_DONE:
            begin
                if (res_st_reg != ST_OK || cmd_reg == CMD_FREE)
                begin
                    res_addr_next = '0;
                end
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall        = (state_reg != S_IDLE) || boot_reg || init_we;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;

endmodule

@@ design/ffca_checker.sv @@
module ffca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] granted_address
);
    import ffca_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_address))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> granted_address == 32'd0)
        else $error("failed transaction carries an address");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction taken while busy");

endmodule

bind first_fit_coalescing_allocator_core ffca_checker u_ffca_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_address(granted_address)
);
